/* design/cmc_pkg.sv */
// Package for the 3x3 color matrix converter.
// Holds the item types, register and mode codes, and reset constants.
// No dependencies.
`timescale 1ns / 1ps

package cmc_pkg;

  localparam int unsigned FRAC_BITS_DEF   = 11;
  localparam int unsigned COEFF_WIDTH_DEF = 16;

  localparam int unsigned CHAN_W     = 16;
  localparam int unsigned TONE_W     = 8;
  localparam int unsigned ROW_W      = 48;
  localparam int unsigned SLOT_W     = 16;
  localparam int unsigned TABLE_AW   = 16;
  localparam int unsigned TABLE_DEPTH = 65536;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [ROW_W-1:0] ROW_RED_RESET   = 48'h0000_0000_0800;
  localparam logic [ROW_W-1:0] ROW_GREEN_RESET = 48'h0000_0800_0000;
  localparam logic [ROW_W-1:0] ROW_BLUE_RESET  = 48'h0800_0000_0000;

  localparam logic [TONE_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [TONE_W-1:0] ALPHA_NONE   = 8'h00;

  typedef enum logic {
    KIND_PIXEL       = 1'b0,
    KIND_TABLE_WRITE = 1'b1
  } cmc_kind_e;

  typedef enum logic {
    MODE_DIRECT16 = 1'b0,
    MODE_TONE8    = 1'b1
  } cmc_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_MODE  = 2'd0,
    REG_ROW_RED   = 2'd1,
    REG_ROW_GREEN = 2'd2,
    REG_ROW_BLUE  = 2'd3
  } cmc_reg_e;

  typedef struct packed {
    cmc_kind_e           kind;
    logic [CHAN_W-1:0]   red_in;
    logic [CHAN_W-1:0]   green_in;
    logic [CHAN_W-1:0]   blue_in;
    logic [TABLE_AW-1:0] table_index;
    logic [TONE_W-1:0]   table_value;
    logic                last_in;
  } cmc_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [TONE_W-1:0] alpha_out;
    logic              last_out;
  } cmc_out_t;

endpackage

/* design/color_matrix_convert.sv */
// Top level of the 3x3 color matrix converter with optional 8-bit tone output.
// Depends on cmc_pkg and cmc_ram.
//
// Usage:
// Items enter on the in_valid_i/in_ready_o channel. A pixel item is multiplied
// by the signed fixed-point matrix, rounded, shifted and clamped to 16 bits. In
// tone mode each channel then addresses the tone table and alpha is 255.
// A table-write item stores one tone value and produces no result.
// Results leave on the out_valid_o/out_ready_i channel, in input order.
// An item passes through four registers from acceptance to out_valid_o:
// input register, multiplier register, clamp register, and the tone table read register.
// Throughput is one item per cycle unless out_ready_i stalls the output; the nine
// multipliers and the three replicated table copies (one read port each) allow it.
// Each stage holds its item only while the next one is full and stalled, so
// in_ready_o stays high while bubbles remain behind a waiting result.
// Registers are written on the cfg channel, which is always ready.
// Reset empties the pipeline and loads the identity matrix and 16-bit mode.
// The tone table is not cleared; entries must be written before a pixel
// reads them in tone mode.
`timescale 1ns / 1ps

module color_matrix_convert
  import cmc_pkg::*;
#(
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  parameter int unsigned COEFF_WIDTH = COEFF_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cmc_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cmc_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ROW_W-1:0]     cfg_data_i
);

  localparam int unsigned PROD_W = CHAN_W + 1 + COEFF_WIDTH;
  localparam int unsigned SUM_W  = (PROD_W + 2 > FRAC_BITS + CHAN_W + 2) ?
                                   PROD_W + 2 : FRAC_BITS + CHAN_W + 2;
  localparam logic [SUM_W-1:0] RoundConst = {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  cmc_mode_e           out_mode_q;
  logic [ROW_W-1:0]    row_q [3];

  logic                v1_q, v2_q, v3_q, v4_q;
  logic                e1, e2, e3, e4;

  cmc_in_t             s1_q;
  cmc_kind_e           kind2_q, kind3_q;
  logic [TABLE_AW-1:0] idx2_q, idx3_q;
  logic [TONE_W-1:0]   val2_q, val3_q;
  logic                last2_q, last3_q, last4_q;
  cmc_mode_e           mode4_q;

  logic [CHAN_W-1:0]        pix1 [3];
  logic signed [COEFF_WIDTH-1:0] coeff [3][3];
  logic signed [PROD_W-1:0] prod_d [3][3];
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic [SUM_W-1:0]         sum_d [3];
  logic [CHAN_W-1:0]        chan_d [3];
  logic [CHAN_W-1:0]        chan3_q [3];
  logic [CHAN_W-1:0]        chan4_q [3];
  logic [TONE_W-1:0]        tone_rd [3];
  logic                     tbl_we;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_mode_q <= MODE_DIRECT16;
      row_q[0]   <= ROW_RED_RESET;
      row_q[1]   <= ROW_GREEN_RESET;
      row_q[2]   <= ROW_BLUE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cmc_reg_e'(cfg_index_i))
        REG_OUT_MODE:  out_mode_q <= cmc_mode_e'(cfg_data_i[0]);
        REG_ROW_RED:   row_q[0]   <= cfg_data_i;
        REG_ROW_GREEN: row_q[1]   <= cfg_data_i;
        REG_ROW_BLUE:  row_q[2]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A table write leaves the clamp stage without taking the output stage.
  always_comb begin
    e4 = !v4_q || out_ready_i;
    e3 = !v3_q || (kind3_q == KIND_TABLE_WRITE) || e4;
    e2 = !v2_q || e3;
    e1 = !v1_q || e2;
  end

  assign in_ready_o  = e1;
  assign tbl_we      = v3_q && (kind3_q == KIND_TABLE_WRITE) && e3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (e1) begin
        v1_q <= in_valid_i;
      end
      if (e2) begin
        v2_q <= v1_q;
      end
      if (e3) begin
        v3_q <= v2_q;
      end
      if (e4) begin
        v4_q <= v3_q && (kind3_q == KIND_PIXEL);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (e1) begin
      s1_q <= in_data_i;
    end
  end

  always_comb begin
    pix1[0] = s1_q.red_in;
    pix1[1] = s1_q.green_in;
    pix1[2] = s1_q.blue_in;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coeff[i][j]  = $signed(row_q[i][j*SLOT_W +: COEFF_WIDTH]);
        prod_d[i][j] = $signed({1'b0, pix1[j]}) * coeff[i][j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (e2) begin
      prod_q  <= prod_d;
      kind2_q <= s1_q.kind;
      idx2_q  <= s1_q.table_index;
      val2_q  <= s1_q.table_value;
      last2_q <= s1_q.last_in;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = SUM_W'(prod_q[i][0]) + SUM_W'(prod_q[i][1]) + SUM_W'(prod_q[i][2])
               + RoundConst;
      if (sum_d[i][SUM_W-1]) begin
        chan_d[i] = '0;
      end else if (|sum_d[i][SUM_W-2:FRAC_BITS+CHAN_W]) begin
        chan_d[i] = '1;
      end else begin
        chan_d[i] = sum_d[i][FRAC_BITS +: CHAN_W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (e3) begin
      chan3_q <= chan_d;
      kind3_q <= kind2_q;
      idx3_q  <= idx2_q;
      val3_q  <= val2_q;
      last3_q <= last2_q;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_tone
    cmc_ram #(
      .WIDTH (TONE_W),
      .DEPTH (TABLE_DEPTH)
    ) u_tone_ram (
      .clk_i   (clk_i),
      .we_i    (tbl_we),
      .waddr_i (idx3_q),
      .wdata_i (val3_q),
      .re_i    (e4),
      .raddr_i (chan3_q[g]),
      .rdata_o (tone_rd[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (e4) begin
      chan4_q <= chan3_q;
      last4_q <= last3_q;
      mode4_q <= out_mode_q;
    end
  end

  assign out_valid_o = v4_q;

  always_comb begin
    out_data_o.last_out = last4_q;
    unique case (mode4_q)
      MODE_TONE8: begin
        out_data_o.red_out   = {{(CHAN_W-TONE_W){1'b0}}, tone_rd[0]};
        out_data_o.green_out = {{(CHAN_W-TONE_W){1'b0}}, tone_rd[1]};
        out_data_o.blue_out  = {{(CHAN_W-TONE_W){1'b0}}, tone_rd[2]};
        out_data_o.alpha_out = ALPHA_OPAQUE;
      end
      default: begin
        out_data_o.red_out   = chan4_q[0];
        out_data_o.green_out = chan4_q[1];
        out_data_o.blue_out  = chan4_q[2];
        out_data_o.alpha_out = ALPHA_NONE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("Input stalled while the pipeline has a bubble.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && (kind3_q == KIND_TABLE_WRITE) && !v4_q) |=> !v4_q)
    else $error("A table write item produced a result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && (mode4_q == MODE_TONE8)) |->
      (out_data_o.red_out[CHAN_W-1:TONE_W] == '0) &&
      (out_data_o.blue_out[CHAN_W-1:TONE_W] == '0) &&
      (out_data_o.alpha_out == ALPHA_OPAQUE))
    else $error("Tone mode result has bits above the tone value.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !out_ready_i) |=> (v4_q && $stable(chan4_q[0]) && $stable(last4_q)))
    else $error("Output stage changed while stalled.");
`endif

endmodule

/* design/cmc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// The read register holds its data while the read enable is low.
// No dependencies.
`timescale 1ns / 1ps

module cmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/color_matrix_convert_tb.sv */
// Self-checking testbench for color_matrix_convert: directed table, then random phases.
// Predicts results from matrix, mode and its own tone-table copy, or uses fixed ones.
// Depends on cmc_pkg and the color_matrix_convert RTL.
`timescale 1ns / 1ps

module color_matrix_convert_tb;
  import cmc_pkg::*;

  localparam int unsigned FRAC        = FRAC_BITS_DEF;
  localparam int unsigned SETTLE      = 10;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 75;
  localparam int unsigned REPORT_MAX  = 100;

  typedef struct {
    bit               is_reg;
    cmc_reg_e         reg_sel;
    logic [ROW_W-1:0] reg_val;
    cmc_in_t          item;
    bit               typed;
    cmc_out_t         result;
  } step_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  cmc_in_t              in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  cmc_out_t             out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ROW_W-1:0]     cfg_data_i  = '0;

  cmc_out_t         pending_px[$];
  step_t            directed_rows[$];
  logic [TONE_W-1:0] tone_copy [TABLE_DEPTH];
  bit               tone_written [TABLE_DEPTH];
  cmc_mode_e        mode_now = MODE_DIRECT16;
  logic [ROW_W-1:0] rows_now [3] = '{ROW_RED_RESET, ROW_GREEN_RESET, ROW_BLUE_RESET};
  int unsigned      fail_count   = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      idle_pct     = 0;
  bit               hold_req     = 1'b0;
  cmc_out_t         head_px;

  color_matrix_convert i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [CHAN_W-1:0] clamp_row(input logic [ROW_W-1:0] row,
                                                  input cmc_in_t it);
    shortint cr, cg, cb;
    longint  acc;
    cr = row[15:0];
    cg = row[31:16];
    cb = row[47:32];
    acc = longint'(it.red_in) * cr + longint'(it.green_in) * cg
        + longint'(it.blue_in) * cb + (longint'(1) << (FRAC - 1));
    if (acc < 0) return '0;
    acc = acc >>> FRAC;
    if (acc > 65535) return 16'hFFFF;
    return acc[15:0];
  endfunction

  function automatic cmc_out_t convert_pixel(input cmc_in_t it);
    cmc_out_t          res;
    logic [CHAN_W-1:0] ch [3];
    for (int k = 0; k < 3; k++) ch[k] = clamp_row(rows_now[k], it);
    if (mode_now == MODE_TONE8) begin
      res.red_out   = {8'h00, tone_copy[ch[0]]};
      res.green_out = {8'h00, tone_copy[ch[1]]};
      res.blue_out  = {8'h00, tone_copy[ch[2]]};
      res.alpha_out = ALPHA_OPAQUE;
    end else begin
      res.red_out   = ch[0];
      res.green_out = ch[1];
      res.blue_out  = ch[2];
      res.alpha_out = ALPHA_NONE;
    end
    res.last_out = it.last_in;
    return res;
  endfunction

  function automatic cmc_in_t px(input logic [CHAN_W-1:0] r, g, b, input logic last);
    cmc_in_t it;
    it = '0;
    it.kind     = KIND_PIXEL;
    it.red_in   = r;
    it.green_in = g;
    it.blue_in  = b;
    it.last_in  = last;
    return it;
  endfunction

  function automatic cmc_in_t tw(input logic [TABLE_AW-1:0] idx, input logic [TONE_W-1:0] val);
    cmc_in_t it;
    it = '0;
    it.kind        = KIND_TABLE_WRITE;
    it.table_index = idx;
    it.table_value = val;
    return it;
  endfunction

  function automatic logic [CHAN_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_item(input cmc_in_t it, input bit typed, input cmc_out_t res);
    step_t st;
    st.is_reg  = 1'b0;
    st.reg_sel = REG_OUT_MODE;
    st.reg_val = '0;
    st.item    = it;
    st.typed   = typed;
    st.result  = res;
    directed_rows.push_back(st);
  endtask

  task automatic add_reg(input cmc_reg_e sel, input logic [ROW_W-1:0] val);
    step_t st;
    st.is_reg  = 1'b1;
    st.reg_sel = sel;
    st.reg_val = val;
    st.item    = '0;
    st.typed   = 1'b0;
    st.result  = '0;
    directed_rows.push_back(st);
  endtask

  task automatic send_item(input cmc_in_t it, input bit typed, input cmc_out_t fixed_res);
    int unsigned gap;
    if ($urandom_range(1, 100) <= idle_pct) begin
      gap = $urandom_range(1, 7);
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (it.kind == KIND_TABLE_WRITE) begin
      tone_copy[it.table_index]    = it.table_value;
      tone_written[it.table_index] = 1'b1;
    end else if (typed) begin
      pending_px.push_back(fixed_res);
    end else begin
      pending_px.push_back(convert_pixel(it));
    end
  endtask

  task automatic write_reg(input cmc_reg_e sel, input logic [ROW_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (sel)
      REG_OUT_MODE:  mode_now    = cmc_mode_e'(val[0]);
      REG_ROW_RED:   rows_now[0] = val;
      REG_ROW_GREEN: rows_now[1] = val;
      REG_ROW_BLUE:  rows_now[2] = val;
      default: ;
    endcase
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  // Table writes give no result, so drain adds a SETTLE wait after the last pixel leaves.
  task automatic drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic check_field(input string fname, input logic [CHAN_W-1:0] want, got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
        $display("%0t: %s expected %h, got %h", $time, fname, want, got);
      end
    end
  endtask

  initial begin : stimulus
    cmc_in_t           it;
    logic [CHAN_W-1:0] idx;
    logic [SLOT_W-1:0] slot;
    logic [ROW_W-1:0]  next_rows [3];
    logic              mode_bit;
    logic [SLOT_W-1:0] extremes [5];

    extremes = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0800};

    add_item(px(16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b1,
             cmc_out_t'{16'h0000, 16'h0000, 16'h0000, ALPHA_NONE, 1'b0});
    add_item(px(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1), 1'b1,
             cmc_out_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, ALPHA_NONE, 1'b1});
    add_item(px(16'h1234, 16'h5678, 16'h9ABC, 1'b0), 1'b1,
             cmc_out_t'{16'h1234, 16'h5678, 16'h9ABC, ALPHA_NONE, 1'b0});
    it = tw(16'h0000, 8'h5A);
    it.red_in   = 16'hFFFF;
    it.green_in = 16'hFFFF;
    it.blue_in  = 16'hFFFF;
    it.last_in  = 1'b1;
    add_item(it, 1'b0, '0);
    add_item(tw(16'hFFFF, 8'hA5), 1'b0, '0);
    add_item(tw(16'h1234, 8'h80), 1'b0, '0);
    add_item(tw(16'h5678, 8'h01), 1'b0, '0);
    add_item(tw(16'h9ABC, 8'hFF), 1'b0, '0);
    add_reg(REG_OUT_MODE, 48'(MODE_TONE8));
    add_item(px(16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b1,
             cmc_out_t'{16'h005A, 16'h005A, 16'h005A, ALPHA_OPAQUE, 1'b0});
    add_item(px(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1), 1'b1,
             cmc_out_t'{16'h00A5, 16'h00A5, 16'h00A5, ALPHA_OPAQUE, 1'b1});
    it = px(16'h1234, 16'h5678, 16'h9ABC, 1'b0);
    it.table_index = 16'hBEEF;
    it.table_value = 8'h3C;
    add_item(it, 1'b0, '0);
    // Upper bits of the mode write must be ignored.
    add_reg(REG_OUT_MODE, 48'hFFFF_FFFF_FFFE);
    add_reg(REG_ROW_RED, 48'hFFFF_FFFF_FFFF);
    add_reg(REG_ROW_GREEN, 48'h7FFF_7FFF_7FFF);
    add_reg(REG_ROW_BLUE, 48'h0000_7FFF_8000);
    add_item(px(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1), 1'b1,
             cmc_out_t'{16'h0000, 16'hFFFF, 16'h0000, ALPHA_NONE, 1'b1});
    add_item(px(16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b1,
             cmc_out_t'{16'h0000, 16'h0000, 16'h0000, ALPHA_NONE, 1'b0});
    add_item(px(16'hFFFF, 16'h0000, 16'h0000, 1'b0), 1'b1,
             cmc_out_t'{16'h0000, 16'hFFFF, 16'h0000, ALPHA_NONE, 1'b0});
    add_item(px(16'h0000, 16'hFFFF, 16'h0000, 1'b0), 1'b0, '0);
    add_item(px(16'h0001, 16'h0000, 16'h0000, 1'b0), 1'b0, '0);
    add_reg(REG_ROW_RED, 48'h0000_0000_0400);
    add_reg(REG_ROW_GREEN, 48'h0000_0000_0000);
    add_reg(REG_ROW_BLUE, 48'h0001_0001_0001);
    add_item(px(16'h0001, 16'h0000, 16'h0000, 1'b0), 1'b0, '0);
    add_item(px(16'h0003, 16'h0005, 16'h0007, 1'b1), 1'b0, '0);
    add_item(px(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0), 1'b0, '0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    idle_pct = 15;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg) begin
        drain();
        write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      for (int r = 0; r < 3; r++) begin
        for (int s = 0; s < 3; s++) begin
          case (ph % 4)
            0: slot = (r == s) ? 16'h0800 : 16'h0000;
            1: slot = (r == s) ? 16'($urandom_range(1024, 3072))
                               : 16'($urandom_range(0, 2048) - 1024);
            2: slot = 16'($urandom);
            default: slot = extremes[$urandom_range(0, 4)];
          endcase
          next_rows[r][16*s +: 16] = slot;
        end
      end
      mode_bit = (ph % 3 == 1);
      write_reg(REG_OUT_MODE, {32'($urandom), 15'($urandom), mode_bit});
      write_reg(REG_ROW_RED, next_rows[0]);
      write_reg(REG_ROW_GREEN, next_rows[1]);
      write_reg(REG_ROW_BLUE, next_rows[2]);

      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 5;
        2: idle_pct = 15;
        default: idle_pct = 30;
      endcase
      if (ph == PHASES - 1) idle_pct = 0;
      if (ph == 2 || ph == 6) hold_req = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 6) == 0) begin
          it = {32'($urandom), 32'($urandom), 10'($urandom)};
          it.kind = KIND_TABLE_WRITE;
          send_item(it, 1'b0, '0);
        end else begin
          it = px(pick_sample(), pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
          it.table_index = 16'($urandom);
          it.table_value = 8'($urandom);
          // In tone mode every entry a pixel will read is written first.
          if (mode_now == MODE_TONE8) begin
            for (int k = 0; k < 3; k++) begin
              idx = clamp_row(rows_now[k], it);
              if (!tone_written[idx]) send_item(tw(idx, 8'($urandom)), 1'b0, '0);
            end
          end
          send_item(it, 1'b0, '0);
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("color_matrix_convert: match");
    end else begin
      $display("color_matrix_convert: mismatch");
    end
    $finish;
  end

  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if ($urandom_range(1, 100) <= idle_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_px.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("%0t: result expected none, got %h", $time, out_data_o);
        end
      end else begin
        head_px = pending_px.pop_front();
        check_field("red_out", head_px.red_out, out_data_o.red_out);
        check_field("green_out", head_px.green_out, out_data_o.green_out);
        check_field("blue_out", head_px.blue_out, out_data_o.blue_out);
        check_field("alpha_out", 16'(head_px.alpha_out), 16'(out_data_o.alpha_out));
        check_field("last_out", 16'(head_px.last_out), 16'(out_data_o.last_out));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("color_matrix_convert: mismatch");
      $finish;
    end
  end

endmodule
